>>> design/flow_key_aggregation_table_unit_defines.svh
// assertion macros for the flow key aggregation table
`ifndef FLOW_KEY_AGGREGATION_TABLE_UNIT_DEFINES_SVH
`define FLOW_KEY_AGGREGATION_TABLE_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define FKA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("%m failed");
`define FKA_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("%m failed");
`else
`define FKA_ASSERT(lbl, clk, rst_n, prop)
`define FKA_ASSERT_NR(lbl, clk, prop)
`endif
`endif

>>> design/fkat_pkg.sv
// shared constants, types and helpers of the flow key aggregation table
`timescale 1ns / 1ps
package fkat_pkg;
  localparam int unsigned TABLE_ENTRIES = 1024;
  localparam int unsigned FIELD_COUNT = 4;
  localparam int unsigned HASH_SLOTS = 2048;
  localparam int unsigned IO_FIELDS = 4;
  localparam int unsigned ACTIVE_FIELDS = (FIELD_COUNT < IO_FIELDS) ? FIELD_COUNT : IO_FIELDS;
  localparam int unsigned EW = $clog2(TABLE_ENTRIES);
  localparam int unsigned SW = $clog2(HASH_SLOTS);
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned AW = $clog2(TABLE_ENTRIES * IO_FIELDS);

  localparam logic [1:0] ACT_AGG = 2'd0;
  localparam logic [1:0] ACT_MERGE = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic [1:0] DIR_ANY = 2'd0;

  localparam logic [2:0] ST_UPDATED = 3'd0;
  localparam logic [2:0] ST_CREATED = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_SKIPPED = 3'd3;
  localparam logic [2:0] ST_READ = 3'd4;

  localparam logic [1:0] KIND_SUM = 2'd0;
  localparam logic [1:0] KIND_MIN = 2'd1;
  localparam logic [1:0] KIND_MAX = 2'd2;
  localparam logic [1:0] KIND_COUNT = 2'd3;

  localparam logic [1:0] REG_KINDS = 2'd0;
  localparam logic [1:0] REG_SIGNED = 2'd1;
  localparam logic [1:0] REG_DIRS = 2'd2;

  localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ALL_ONES64 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] POS_LIMIT64 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIMIT64 = SIGN_BIT;

  localparam logic [63:0] HASH_M1 = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] HASH_M2 = 64'hBF58_476D_1CE4_E5B9;

  // 64x64 low product split into 32-bit partial products
  typedef struct packed {
    logic [63:0] ll;
    logic [31:0] lh;
    logic [31:0] hl;
  } pprod_t;

  function automatic pprod_t mul_parts(input logic [63:0] a, input logic [63:0] b);
    pprod_t p;
    p.ll = {32'd0, a[31:0]} * {32'd0, b[31:0]};
    p.lh = a[31:0] * b[63:32];
    p.hl = a[63:32] * b[31:0];
    return p;
  endfunction

  function automatic logic [63:0] mul_sum(input pprod_t p);
    return p.ll + {p.lh + p.hl, 32'd0};
  endfunction

  function automatic logic [63:0] kind_start(input logic [1:0] kind, input logic sgn);
    logic [63:0] r;
    r = 64'd0;
    if (kind == KIND_MIN) r = sgn ? POS_LIMIT64 : ALL_ONES64;
    else if (kind == KIND_MAX) r = sgn ? NEG_LIMIT64 : 64'd0;
    return r;
  endfunction

  function automatic logic [63:0] combine(input logic [1:0] kind, input logic sgn,
                                          input logic [63:0] cur, input logic [63:0] v,
                                          input logic merging);
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] r;
    x = sgn ? (v ^ SIGN_BIT) : v;
    y = sgn ? (cur ^ SIGN_BIT) : cur;
    case (kind)
      KIND_SUM: r = cur + v;
      KIND_MIN: r = (x < y) ? v : cur;
      KIND_MAX: r = (x > y) ? v : cur;
      default: r = merging ? cur + v : cur + 64'd1;
    endcase
    return r;
  endfunction
endpackage

>>> design/flow_key_aggregation_table_unit.sv
// flow key aggregation table: hash lookup, entry create, field update and entry read
// each further probe step past the first slot goes through slot read, key read and compare
// one item in flight, the next is accepted the cycle after its result is registered
// after reset: a clearing pass over all HASH_SLOTS slots empties the slot memory, no item is
// accepted meanwhile; reset clears control state, entry count and configuration registers
`timescale 1ns / 1ps
`include "flow_key_aggregation_table_unit_defines.svh"
module flow_key_aggregation_table_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [7:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // action, key_high, key_low, key_valid, direction, value_0..3, value_present, read_index
  input  logic [407:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status, entry_index, out_key_high, out_key_low, out_value_0..3, entry_total
  output logic [407:0] m_axis_tdata
);
  import fkat_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_H1 = 4'd2;
  localparam logic [3:0] S_H2 = 4'd3;
  localparam logic [3:0] S_H3 = 4'd4;
  localparam logic [3:0] S_H4 = 4'd5;
  localparam logic [3:0] S_PRD = 4'd6;
  localparam logic [3:0] S_PSL = 4'd7;
  localparam logic [3:0] S_PKEY = 4'd8;
  localparam logic [3:0] S_FRD = 4'd9;
  localparam logic [3:0] S_FUPD = 4'd10;
  localparam logic [3:0] S_OUT = 4'd11;
  localparam logic [3:0] S_PKA = 4'd12;

  // configuration registers
  logic [7:0] kinds_q, dirs_q;
  logic [3:0] sgn_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kinds_q <= '0; sgn_q <= '0; dirs_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_KINDS: kinds_q <= cfg_wdata_i;
        REG_SIGNED: sgn_q <= cfg_wdata_i[3:0];
        REG_DIRS: dirs_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // memories
  logic [EW:0]   slot_mem [HASH_SLOTS];
  logic [63:0]   khi_mem [TABLE_ENTRIES];
  logic [63:0]   klo_mem [TABLE_ENTRIES];
  logic [63:0]   agg_mem [TABLE_ENTRIES * IO_FIELDS];

  logic [3:0]   state_q;
  logic [SW:0]  clr_q;
  logic [CW-1:0] used_q;
  logic [1:0]   act_q;
  logic [63:0]  khi_q, klo_q;
  logic [1:0]   dir_q;
  logic [63:0]  val_q [IO_FIELDS];
  logic [3:0]   pres_q;
  logic [EW-1:0] ridx_q;
  logic [63:0]  h_q;
  pprod_t       pp_q;
  logic [SW-1:0] pos_q;
  logic [SW:0]  steps_q;
  logic [EW:0]  slot_rd_q;
  logic [63:0]  khi_rd_q, klo_rd_q, agg_rd_q;
  logic [EW-1:0] ent_q;
  logic         new_q;
  logic [1:0]   fld_q;
  logic [2:0]   fcnt_q;
  logic [63:0]  res_q [IO_FIELDS];
  logic [2:0]   st_q;
  logic         ov_q;
  logic [407:0] out_q;

  // slot memory port
  logic          sl_we;
  logic [SW-1:0] sl_wa;
  logic [EW:0]   sl_wd;
  always_ff @(posedge clk_i) begin
    if (sl_we) slot_mem[sl_wa] <= sl_wd;
    slot_rd_q <= slot_mem[pos_q];
  end

  // key memories
  logic          k_we;
  logic [EW-1:0] k_wa;
  logic [EW-1:0] k_ra;
  always_ff @(posedge clk_i) begin
    if (k_we) begin
      khi_mem[k_wa] <= khi_q;
      klo_mem[k_wa] <= klo_q;
    end
    khi_rd_q <= khi_mem[k_ra];
    klo_rd_q <= klo_mem[k_ra];
  end

  // aggregate memory
  logic          a_we;
  logic [63:0]   a_wd;
  logic [AW-1:0] a_addr;
  assign a_addr = {ent_q, fld_q};
  always_ff @(posedge clk_i) begin
    if (a_we) agg_mem[a_addr] <= a_wd;
    agg_rd_q <= agg_mem[a_addr];
  end

  // field update of the current field
  logic [1:0]  f_kind, f_dir;
  logic        f_sgn, f_apply;
  logic [63:0] f_cur, f_new;
  always_comb begin
    f_kind = kinds_q[2*fld_q +: 2];
    f_dir = dirs_q[2*fld_q +: 2];
    f_sgn = sgn_q[fld_q];
    f_cur = new_q ? kind_start(f_kind, f_sgn) : agg_rd_q;
    if (act_q == ACT_MERGE) begin
      f_apply = 1'b1;
      f_new = new_q ? val_q[fld_q] : combine(f_kind, f_sgn, f_cur, val_q[fld_q], 1'b1);
    end else begin
      f_apply = (f_dir == DIR_ANY || f_dir == dir_q) &&
                (f_kind == KIND_COUNT || pres_q[fld_q]);
      f_new = f_apply ? combine(f_kind, f_sgn, f_cur, val_q[fld_q], 1'b0) : f_cur;
    end
  end

  // probe decision on the slot word and the key it points at
  logic slot_empty, table_full, slot_hit;
  assign slot_empty = (slot_rd_q == '0);
  assign table_full = (used_q >= CW'(TABLE_ENTRIES));
  assign slot_hit = !slot_empty && (slot_rd_q - 1'b1 < used_q) &&
                    (khi_rd_q == khi_q) && (klo_rd_q == klo_q);

  assign sl_we = (state_q == S_CLEAR) ||
                 (state_q == S_PKEY && slot_empty && !table_full);
  assign sl_wa = (state_q == S_CLEAR) ? clr_q[SW-1:0] : pos_q;
  assign sl_wd = (state_q == S_CLEAR) ? '0 : used_q + 1'b1;
  assign k_we = (state_q == S_PKEY) && slot_empty && !table_full;
  assign k_wa = used_q[EW-1:0];
  assign k_ra = (state_q == S_PKA) ? slot_rd_q[EW-1:0] - 1'b1 : ridx_q;
  assign a_we = (state_q == S_FUPD) && (act_q != ACT_READ);
  assign a_wd = f_new;

  assign s_axis_tready = (state_q == S_IDLE);
  logic [63:0] hash_fin;
  assign hash_fin = h_q ^ (h_q >> 32);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; clr_q <= '0; used_q <= '0; ov_q <= 1'b0;
    end else begin
      // output register handshake
      if (state_q == S_OUT && (!ov_q || m_axis_tready)) ov_q <= 1'b1;
      else if (m_axis_tready) ov_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == (SW+1)'(HASH_SLOTS - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            act_q <= s_axis_tdata[1:0];
            khi_q <= s_axis_tdata[65:2];
            klo_q <= s_axis_tdata[129:66];
            dir_q <= s_axis_tdata[132:131];
            for (int f = 0; f < IO_FIELDS; f++) val_q[f] <= s_axis_tdata[133+64*f +: 64];
            pres_q <= s_axis_tdata[392:389];
            ridx_q <= s_axis_tdata[402:393];
            pp_q <= mul_parts(s_axis_tdata[129:66], HASH_M1);
            if (s_axis_tdata[1:0] == ACT_READ) begin
              state_q <= S_PRD;
            end else if (s_axis_tdata[1:0] == ACT_UNUSED || !s_axis_tdata[130]) begin
              st_q <= ST_SKIPPED; ent_q <= '0; state_q <= S_OUT;
              for (int f = 0; f < IO_FIELDS; f++) res_q[f] <= '0;
            end else begin
              state_q <= S_H1;
            end
          end
        end
        S_H1: begin
          h_q <= khi_q ^ mul_sum(pp_q);
          state_q <= S_H2;
        end
        S_H2: begin
          pp_q <= mul_parts(h_q ^ (h_q >> 29), HASH_M2);
          state_q <= S_H3;
        end
        S_H3: begin
          h_q <= mul_sum(pp_q);
          state_q <= S_H4;
        end
        S_H4: begin
          pos_q <= hash_fin[SW-1:0];
          steps_q <= '0;
          state_q <= S_PSL;
        end
        S_PRD: begin
          // key read for the read action, data valid next cycle
          ent_q <= ridx_q;
          fld_q <= '0;
          if ({1'b0, ridx_q} < used_q) begin
            st_q <= ST_READ; new_q <= 1'b0; fcnt_q <= '0; act_q <= ACT_READ;
            state_q <= S_FRD;
          end else begin
            st_q <= ST_SKIPPED; state_q <= S_OUT;
            for (int f = 0; f < IO_FIELDS; f++) res_q[f] <= '0;
          end
        end
        // slot word read at the probe position
        S_PSL: state_q <= S_PKA;
        // key read of the entry named by the slot word
        S_PKA: state_q <= S_PKEY;
        S_PKEY: begin
          fld_q <= '0; fcnt_q <= '0;
          new_q <= slot_empty;
          if (slot_empty) begin
            if (table_full) begin
              st_q <= ST_FULL; ent_q <= '0; state_q <= S_OUT;
              for (int f = 0; f < IO_FIELDS; f++) res_q[f] <= '0;
            end else begin
              ent_q <= used_q[EW-1:0];
              used_q <= used_q + 1'b1;
              st_q <= ST_CREATED; state_q <= S_FRD;
            end
          end else if (slot_hit) begin
            ent_q <= slot_rd_q[EW-1:0] - 1'b1;
            st_q <= ST_UPDATED; state_q <= S_FRD;
          end else if (steps_q == (SW+1)'(HASH_SLOTS - 1)) begin
            st_q <= ST_FULL; ent_q <= '0; state_q <= S_OUT;
            for (int f = 0; f < IO_FIELDS; f++) res_q[f] <= '0;
          end else begin
            steps_q <= steps_q + 1'b1;
            pos_q <= pos_q + 1'b1;
            state_q <= S_PSL;
          end
        end
        S_FRD: state_q <= S_FUPD;
        S_FUPD: begin
          res_q[fld_q] <= (act_q == ACT_READ) ? agg_rd_q :
                          (fcnt_q < 3'(ACTIVE_FIELDS)) ? f_new : 64'd0;
          fld_q <= fld_q + 1'b1;
          fcnt_q <= fcnt_q + 1'b1;
          state_q <= (fcnt_q == 3'(IO_FIELDS - 1)) ? S_OUT : S_FRD;
        end
        S_OUT: begin
          if (!ov_q || m_axis_tready) begin
            out_q[2:0] <= st_q;
            out_q[12:3] <= (st_q == ST_SKIPPED && act_q == ACT_READ) ? ridx_q :
                           (st_q == ST_SKIPPED || st_q == ST_FULL) ? 10'd0 : ent_q;
            out_q[76:13] <= (st_q == ST_SKIPPED || st_q == ST_FULL) ? 64'd0 :
                            (st_q == ST_READ) ? khi_rd_q : khi_q;
            out_q[140:77] <= (st_q == ST_SKIPPED || st_q == ST_FULL) ? 64'd0 :
                             (st_q == ST_READ) ? klo_rd_q : klo_q;
            for (int f = 0; f < IO_FIELDS; f++)
              out_q[141+64*f +: 64] <= (f < ACTIVE_FIELDS) ? res_q[f] : 64'd0;
            out_q[407:397] <= used_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata = out_q;

  `FKA_ASSERT(a_no_accept_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
  `FKA_ASSERT(a_used_bound, clk_i, rst_ni, used_q <= CW'(TABLE_ENTRIES))
  `FKA_ASSERT(a_clear_no_ready, clk_i, rst_ni, state_q == S_CLEAR |-> !s_axis_tready)
endmodule

>>> sim/fkat_checker.sv
// checker for the flow key aggregation table: predicts each result and compares
`timescale 1ns / 1ps
module fkat_checker
  import fkat_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [7:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [407:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [407:0] m_axis_tdata,
  output int           fail_count_o,
  output int           pending_o
);

  // most significant field first, status lands in the lowest bits
  typedef struct packed {
    logic [10:0] entry_total;
    logic [63:0] val3;
    logic [63:0] val2;
    logic [63:0] val1;
    logic [63:0] val0;
    logic [63:0] key_low;
    logic [63:0] key_high;
    logic [9:0]  entry_index;
    logic [2:0]  status;
  } flow_result_t;

  // model copy of the table
  logic [63:0] tbl_key_high [TABLE_ENTRIES];
  logic [63:0] tbl_key_low  [TABLE_ENTRIES];
  logic [63:0] tbl_agg      [TABLE_ENTRIES][IO_FIELDS];
  int unsigned slot_map     [HASH_SLOTS];
  int unsigned used_count;
  logic [7:0]  kinds_reg;
  logic [3:0]  signed_reg;
  logic [7:0]  dirs_reg;

  flow_result_t expected_results[$];

  function automatic int unsigned flow_hash(logic [63:0] hi, logic [63:0] lo);
    logic [63:0] h;
    h = hi ^ (lo * 64'h9E3779B97F4A7C15);
    h = h ^ (h >> 29);
    h = h * 64'hBF58476D1CE4E5B9;
    h = h ^ (h >> 32);
    return int'(h % HASH_SLOTS);
  endfunction

  function automatic logic [63:0] fold_value(int f, logic [63:0] cur, logic [63:0] v,
                                             bit merging);
    logic [1:0] k;
    bit sg;
    logic [63:0] x;
    logic [63:0] y;
    k = kinds_reg[2*f +: 2];
    sg = signed_reg[f];
    x = sg ? v ^ SIGN_BIT : v;
    y = sg ? cur ^ SIGN_BIT : cur;
    case (k)
      KIND_SUM: return cur + v;
      KIND_MIN: return (x < y) ? v : cur;
      KIND_MAX: return (x > y) ? v : cur;
      default:  return merging ? cur + v : cur + 64'd1;
    endcase
  endfunction

  function automatic logic [63:0] start_value(int f);
    logic [1:0] k;
    k = kinds_reg[2*f +: 2];
    if (k == KIND_MIN) return signed_reg[f] ? POS_LIMIT64 : ALL_ONES64;
    if (k == KIND_MAX) return signed_reg[f] ? NEG_LIMIT64 : 64'd0;
    return 64'd0;
  endfunction

  function automatic flow_result_t entry_result(logic [2:0] st, int unsigned idx, int e);
    flow_result_t r;
    r = '0;
    r.status = st;
    r.entry_index = idx[9:0];
    if (e >= 0) begin
      r.key_high = tbl_key_high[e];
      r.key_low = tbl_key_low[e];
      r.val0 = tbl_agg[e][0];
      r.val1 = tbl_agg[e][1];
      r.val2 = tbl_agg[e][2];
      r.val3 = tbl_agg[e][3];
    end
    r.entry_total = used_count[10:0];
    return r;
  endfunction

  // apply one input transaction to the model table
  function automatic flow_result_t update_table(logic [407:0] d);
    logic [1:0]  act;
    logic [63:0] hi;
    logic [63:0] lo;
    logic        kv;
    logic [1:0]  dir;
    logic [63:0] vals [4];
    logic [3:0]  pres;
    logic [9:0]  ridx;
    int unsigned base;
    int unsigned pos;
    int unsigned s;
    int          hit;
    int          free_slot;
    int          e;
    bit          created;
    logic [1:0]  fd;
    act = d[1:0];
    hi = d[65:2];
    lo = d[129:66];
    kv = d[130];
    dir = d[132:131];
    for (int f = 0; f < 4; f++) vals[f] = d[133 + 64*f +: 64];
    pres = d[392:389];
    ridx = d[402:393];
    hit = -1;
    free_slot = -1;
    if (act == ACT_READ) begin
      if (ridx < used_count) return entry_result(ST_READ, int'(ridx), int'(ridx));
      return entry_result(ST_SKIPPED, int'(ridx), -1);
    end
    if (act == ACT_UNUSED || !kv) return entry_result(ST_SKIPPED, 0, -1);
    base = flow_hash(hi, lo);
    for (int i = 0; i < HASH_SLOTS; i++) begin
      pos = (base + i) % HASH_SLOTS;
      s = slot_map[pos];
      if (s == 0) begin
        free_slot = pos;
        break;
      end
      if (s - 1 < used_count && tbl_key_high[s-1] == hi && tbl_key_low[s-1] == lo) begin
        hit = s - 1;
        break;
      end
    end
    created = 0;
    if (hit >= 0) begin
      e = hit;
    end else begin
      if (used_count >= TABLE_ENTRIES || free_slot < 0) return entry_result(ST_FULL, 0, -1);
      e = used_count;
      used_count++;
      slot_map[free_slot] = e + 1;
      tbl_key_high[e] = hi;
      tbl_key_low[e] = lo;
      created = 1;
      for (int f = 0; f < 4; f++)
        tbl_agg[e][f] = (act == ACT_MERGE) ? vals[f] : start_value(f);
      if (act == ACT_MERGE) return entry_result(ST_CREATED, e, e);
    end
    for (int f = 0; f < 4; f++) begin
      fd = dirs_reg[2*f +: 2];
      if (act == ACT_MERGE) begin
        tbl_agg[e][f] = fold_value(f, tbl_agg[e][f], vals[f], 1);
      end else if ((fd == DIR_ANY || fd == dir) &&
                   (kinds_reg[2*f +: 2] == KIND_COUNT || pres[f])) begin
        tbl_agg[e][f] = fold_value(f, tbl_agg[e][f], vals[f], 0);
      end
    end
    return entry_result(created ? ST_CREATED : ST_UPDATED, e, e);
  endfunction

  assign pending_o = expected_results.size();

  // watch configuration, input and output transactions
  always @(posedge clk_i or negedge rst_ni) begin
    flow_result_t got;
    flow_result_t exp_r;
    if (!rst_ni) begin
      used_count = 0;
      kinds_reg = '0;
      signed_reg = '0;
      dirs_reg = '0;
      fail_count_o = 0;
      for (int i = 0; i < HASH_SLOTS; i++) slot_map[i] = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_KINDS) kinds_reg = cfg_wdata_i;
        else if (cfg_index_i == REG_SIGNED) signed_reg = cfg_wdata_i[3:0];
        else if (cfg_index_i == REG_DIRS) dirs_reg = cfg_wdata_i;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, actual %h", $time, got);
          fail_count_o++;
        end else begin
          exp_r = expected_results.pop_front();
          if (got.status !== exp_r.status || got.entry_index !== exp_r.entry_index ||
              got.key_high !== exp_r.key_high || got.key_low !== exp_r.key_low ||
              got.val0 !== exp_r.val0 || got.val1 !== exp_r.val1 ||
              got.val2 !== exp_r.val2 || got.val3 !== exp_r.val3 ||
              got.entry_total !== exp_r.entry_total) begin
            $display("%0t: mismatch, expected %h, actual %h", $time, exp_r, got);
            fail_count_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_results.insert(expected_results.size(), update_table(s_axis_tdata));
    end
  end

endmodule

>>> sim/testbench.sv
// top of the flow key aggregation table test: stimulus, idling and verdict
`timescale 1ns / 1ps
module testbench;
  import fkat_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         cfg_we_i = 0;
  logic [1:0]   cfg_index_i = '0;
  logic [7:0]   cfg_wdata_i = '0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [407:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [407:0] m_axis_tdata;
  int           fail_count;
  int           pending;
  int           idle_cycles = 0;
  bit           hold_off = 0;

  logic [63:0] key_pool_high [16];
  logic [63:0] key_pool_low  [16];

  always #6 clk_i = ~clk_i;

  flow_key_aggregation_table_unit uut (.*);

  fkat_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] edge_value();
    case ($urandom_range(0, 5))
      0: return 64'd0;
      1: return ALL_ONES64;
      2: return POS_LIMIT64;
      3: return NEG_LIMIT64;
      4: return 64'd1;
      default: return rand64();
    endcase
  endfunction

  function automatic logic [407:0] make_item(logic [1:0] act, logic [63:0] hi, logic [63:0] lo,
                                             logic kv, logic [1:0] dir, logic [3:0] pres,
                                             logic [9:0] ridx);
    logic [407:0] d;
    d = '0;
    d[1:0] = act;
    d[65:2] = hi;
    d[129:66] = lo;
    d[130] = kv;
    d[132:131] = dir;
    for (int f = 0; f < 4; f++) d[133 + 64*f +: 64] = edge_value();
    d[392:389] = pres;
    d[402:393] = ridx;
    return d;
  endfunction

  // send one item, honoring bursts and gaps
  task automatic send_item(logic [407:0] d);
    if ($urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] v);
    cfg_we_i <= 1;
    cfg_index_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  // random item mostly on a small pool of keys so entries get updated
  function automatic logic [407:0] random_item();
    logic [1:0] act;
    int k;
    int r;
    r = $urandom_range(0, 99);
    act = (r < 60) ? ACT_AGG : (r < 80) ? ACT_MERGE : (r < 95) ? ACT_READ : ACT_UNUSED;
    k = $urandom_range(0, 15);
    if ($urandom_range(0, 3) == 0)
      return make_item(act, rand64(), rand64(), $urandom_range(0, 9) != 0,
                       2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                       10'($urandom_range(0, 1023)));
    return make_item(act, key_pool_high[k], key_pool_low[k], $urandom_range(0, 9) != 0,
                     2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                     10'($urandom_range(0, 40)));
  endfunction

  // receiver stalls on its own pattern, with one long hold-off
  always @(posedge clk_i) begin
    if (hold_off) m_axis_tready <= 0;
    else if ($urandom_range(0, 2) == 0) m_axis_tready <= ($urandom_range(0, 3) != 0);
    else if ($urandom_range(0, 30) == 0) m_axis_tready <= 1;
  end

  // watchdog on cycles with no transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni ||
        hold_off)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 16; i++) begin
      key_pool_high[i] = rand64();
      key_pool_low[i] = rand64();
    end
    key_pool_high[0] = '0;
    key_pool_low[0] = '0;
    key_pool_high[1] = ALL_ONES64;
    key_pool_low[1] = ALL_ONES64;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    write_reg(REG_KINDS, 8'b11_10_01_00);
    write_reg(REG_SIGNED, 4'b0110);
    write_reg(REG_DIRS, 8'b11_10_01_00);

    // directed: extremes, every action, skips, reads beyond range
    send_item(make_item(ACT_READ, 0, 0, 1, 0, 0, 0));
    send_item(make_item(ACT_AGG, key_pool_high[0], key_pool_low[0], 1, 0, 4'hF, 0));
    for (int d = 0; d < 4; d++)
      send_item(make_item(ACT_AGG, key_pool_high[0], key_pool_low[0], 1, 2'(d), 4'hF, 0));
    send_item(make_item(ACT_AGG, key_pool_high[0], key_pool_low[0], 1, 3, 4'h0, 0));
    send_item(make_item(ACT_AGG, key_pool_high[1], key_pool_low[1], 1, 3, 4'hF, 0));
    send_item(make_item(ACT_MERGE, key_pool_high[1], key_pool_low[1], 1, 0, 0, 0));
    send_item(make_item(ACT_MERGE, key_pool_high[2], key_pool_low[2], 1, 0, 0, 0));
    send_item(make_item(ACT_MERGE, key_pool_high[2], key_pool_low[2], 1, 0, 0, 0));
    send_item(make_item(ACT_AGG, key_pool_high[3], key_pool_low[3], 0, 1, 4'hF, 10'h3FF));
    send_item(make_item(ACT_MERGE, key_pool_high[3], key_pool_low[3], 0, 2, 4'hF, 0));
    send_item(make_item(ACT_UNUSED, ALL_ONES64, ALL_ONES64, 1, 3, 4'hF, 10'h3FF));
    send_item(make_item(ACT_READ, 0, 0, 1, 0, 0, 2));
    send_item(make_item(ACT_READ, 0, 0, 1, 0, 0, 3));
    send_item(make_item(ACT_READ, 0, 0, 1, 0, 0, 10'h3FF));
    drain();

    // random phases across register settings
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_KINDS, 8'h00);
          write_reg(REG_SIGNED, 4'h0);
          write_reg(REG_DIRS, 8'h00);
        end
        1: begin
          write_reg(REG_KINDS, 8'hFF);
          write_reg(REG_SIGNED, 4'hF);
          write_reg(REG_DIRS, 8'hFF);
        end
        2: begin
          write_reg(REG_KINDS, 8'h55);
          write_reg(REG_SIGNED, 4'hF);
          write_reg(REG_DIRS, 8'b10_01_10_01);
        end
        3: begin
          write_reg(REG_KINDS, 8'hAA);
          write_reg(REG_SIGNED, 4'h0);
          write_reg(REG_DIRS, 8'h00);
        end
        default: begin
          write_reg(REG_KINDS, 8'($urandom_range(0, 255)));
          write_reg(REG_SIGNED, 8'($urandom_range(0, 15)));
          write_reg(REG_DIRS, 8'($urandom_range(0, 255)));
        end
      endcase
      for (int n = 0; n < 280; n++) begin
        if (phase == 2 && n == 100) begin
          // keep offering while the output is held off
          hold_off <= 1;
          fork
            begin
              repeat (300) @(posedge clk_i);
              hold_off <= 0;
            end
          join_none
        end
        send_item(random_item());
      end
      drain();
    end

    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
